### rtl/core/obrb_pkg.sv
// Package for the overwriting byte ring buffer.
// Holds field widths, operation codes, the input/result word types and the
// index wrap helper used by the control module; the control, store and top-level modules share it.
package obrb_pkg;

    localparam int SIZE_W        = 11;
    localparam int DATA_W        = 8;
    localparam int POS_W         = 10;
    localparam int OP_W          = 3;
    localparam int DEFAULT_DEPTH = 1024;

    localparam logic [OP_W-1:0] OP_WRITE   = 3'd0;
    localparam logic [OP_W-1:0] OP_POP     = 3'd1;
    localparam logic [OP_W-1:0] OP_PEEK    = 3'd2;
    localparam logic [OP_W-1:0] OP_ADVANCE = 3'd3;
    localparam logic [OP_W-1:0] OP_FLUSH   = 3'd4;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [DATA_W-1:0] data_byte;
        logic [SIZE_W-1:0] amount;
        logic [POS_W-1:0]  position;
    } in_t;

    typedef struct packed {
        logic [DATA_W-1:0] read_byte;
        logic              byte_valid;
        logic [SIZE_W-1:0] moved;
        logic              overwrote;
        logic [SIZE_W-1:0] fill_level;
        logic [SIZE_W-1:0] free_space;
    } out_t;

    typedef struct packed {
        out_t res;
        logic use_mem;
    } stage_t;

    typedef struct packed {
        logic we;
        logic re;
    } mem_cmd_t;

    function automatic logic [SIZE_W-1:0] wrap_add(
        input logic [SIZE_W-1:0] base,
        input logic [SIZE_W-1:0] step,
        input logic [SIZE_W-1:0] size
    );
        logic [SIZE_W:0] s;
        s = {1'b0, base} + {1'b0, step};
        if (s >= {1'b0, size}) begin
            s = s - {1'b0, size};
        end
        return s[SIZE_W-1:0];
    endfunction

endpackage

### rtl/core/obrb_store.sv
// Byte store of the ring buffer: one address, shared by a write and a read access per cycle.
// Read data is registered and holds until the next read. Uses obrb_pkg.
module obrb_store #(
    parameter int DEPTH = obrb_pkg::DEFAULT_DEPTH,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                      aclk,
    input  obrb_pkg::mem_cmd_t        cmd,
    input  logic [AW-1:0]             addr,
    input  logic [obrb_pkg::DATA_W-1:0] wdata,
    output logic [obrb_pkg::DATA_W-1:0] rdata
);
    import obrb_pkg::*;

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (cmd.we) begin
            mem[addr] <= wdata;
        end
        if (cmd.re) begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/core/obrb_ctrl.sv
// Index, fill and size bookkeeping of the ring buffer plus the access stage.
// Decodes each word, issues the store access and updates state. Uses obrb_pkg.
module obrb_ctrl #(
    parameter int DEPTH = obrb_pkg::DEFAULT_DEPTH,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_wr_en,
    input  logic [obrb_pkg::SIZE_W-1:0] cfg_wr_data,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  obrb_pkg::in_t               s_data,
    input  logic                        p1_take,
    output logic                        p1_valid,
    output obrb_pkg::stage_t            p1_data,
    output obrb_pkg::mem_cmd_t          mem_cmd,
    output logic [AW-1:0]               mem_addr,
    output logic [obrb_pkg::DATA_W-1:0] mem_wdata
);
    import obrb_pkg::*;

    logic [SIZE_W-1:0] size_reg, size_next;
    logic [SIZE_W-1:0] rd_reg, rd_next;
    logic [SIZE_W-1:0] wr_reg, wr_next;
    logic [SIZE_W-1:0] fill_reg, fill_next;
    logic              p1_valid_reg, p1_valid_next;
    stage_t            p1_reg, p1_next;

    logic              accept;
    logic [SIZE_W-1:0] rd_step;
    logic [SIZE_W-1:0] rd_sum;
    logic [SIZE_W-1:0] wr_inc;
    logic [SIZE_W-1:0] adv_n;
    logic [SIZE_W-1:0] cfg_size;
    logic [31:0]       cfg_ext;

    assign s_ready = !p1_valid_reg || p1_take;
    assign accept  = s_valid && s_ready;

    assign adv_n  = (s_data.amount < fill_reg) ? s_data.amount : fill_reg;
    assign wr_inc = wrap_add(wr_reg, SIZE_W'(1), size_reg);
    assign rd_sum = wrap_add(rd_reg, rd_step, size_reg);

    always_comb begin
        case (s_data.op)
            OP_POP:     rd_step = SIZE_W'(1);
            OP_PEEK:    rd_step = SIZE_W'(s_data.position);
            OP_ADVANCE: rd_step = adv_n;
            default:    rd_step = '0;
        endcase
    end

    always_comb begin
        cfg_ext  = 32'(cfg_wr_data);
        cfg_size = cfg_wr_data;
        if (cfg_wr_data == '0) begin
            cfg_size = SIZE_W'(1);
        end else if (cfg_ext > 32'(DEPTH)) begin
            cfg_size = SIZE_W'(DEPTH);
        end
    end

    always_comb begin
        size_next     = size_reg;
        rd_next       = rd_reg;
        wr_next       = wr_reg;
        fill_next     = fill_reg;
        p1_next       = p1_reg;
        p1_valid_next = p1_valid_reg;
        mem_cmd       = '0;
        mem_addr      = AW'(rd_reg);
        mem_wdata     = s_data.data_byte;

        if (p1_take) begin
            p1_valid_next = 1'b0;
        end

        if (cfg_wr_en) begin
            size_next = cfg_size;
            rd_next   = '0;
            wr_next   = '0;
            fill_next = '0;
        end else if (accept) begin
            p1_valid_next       = 1'b1;
            p1_next             = '0;
            case (s_data.op)
                OP_WRITE: begin
                    mem_cmd.we = 1'b1;
                    mem_addr   = AW'(wr_reg);
                    wr_next    = wr_inc;
                    if (fill_reg >= size_reg) begin
                        p1_next.res.overwrote = 1'b1;
                        fill_next             = size_reg;
                        rd_next               = wr_inc;
                    end else begin
                        fill_next = fill_reg + SIZE_W'(1);
                    end
                    p1_next.res.moved = SIZE_W'(1);
                end
                OP_POP: begin
                    if (fill_reg != '0) begin
                        mem_cmd.re             = 1'b1;
                        mem_addr               = AW'(rd_reg);
                        p1_next.use_mem        = 1'b1;
                        p1_next.res.byte_valid = 1'b1;
                        p1_next.res.moved      = SIZE_W'(1);
                        rd_next                = rd_sum;
                        fill_next              = fill_reg - SIZE_W'(1);
                        if (fill_reg == SIZE_W'(1)) begin
                            rd_next = '0;
                            wr_next = '0;
                        end
                    end
                end
                OP_PEEK: begin
                    if (SIZE_W'(s_data.position) < fill_reg) begin
                        mem_cmd.re             = 1'b1;
                        mem_addr               = AW'(rd_sum);
                        p1_next.use_mem        = 1'b1;
                        p1_next.res.byte_valid = 1'b1;
                    end
                end
                OP_ADVANCE: begin
                    rd_next           = rd_sum;
                    fill_next         = fill_reg - adv_n;
                    p1_next.res.moved = adv_n;
                    if (adv_n == fill_reg) begin
                        rd_next = '0;
                        wr_next = '0;
                    end
                end
                OP_FLUSH: begin
                    rd_next   = '0;
                    wr_next   = '0;
                    fill_next = '0;
                end
                default: begin
                end
            endcase
            p1_next.res.fill_level = fill_next;
            p1_next.res.free_space = size_reg - fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            size_reg     <= SIZE_W'(DEPTH);
            rd_reg       <= '0;
            wr_reg       <= '0;
            fill_reg     <= '0;
            p1_valid_reg <= 1'b0;
        end else begin
            size_reg     <= size_next;
            rd_reg       <= rd_next;
            wr_reg       <= wr_next;
            fill_reg     <= fill_next;
            p1_valid_reg <= p1_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        p1_reg <= p1_next;
    end

    assign p1_valid = p1_valid_reg;
    assign p1_data  = p1_reg;

endmodule

### rtl/core/overwriting_byte_ring_buffer.sv
// Overwriting byte ring buffer, top level: control, byte store, output register.
// Throughput: one word per cycle unless the output stalls; a single store port serves
// each word's access, if any; a result passes the access stage and output register.
// Reset: synchronous active-low aresetn; size returns to DEPTH, buffer empties.
// Store contents are not cleared by reset; no clearing pass is needed.
// Depends on obrb_pkg, obrb_ctrl, obrb_store.
module overwriting_byte_ring_buffer #(
    parameter int DEPTH = obrb_pkg::DEFAULT_DEPTH
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_wr_en,
    input  logic [obrb_pkg::SIZE_W-1:0] cfg_wr_data,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  obrb_pkg::in_t               s_data,
    output logic                        m_valid,
    input  logic                        m_ready,
    output obrb_pkg::out_t              m_data
);
    import obrb_pkg::*;

    localparam int AW = $clog2(DEPTH);

    logic              p1_valid;
    logic              p1_take;
    stage_t            p1_data;
    mem_cmd_t          mem_cmd;
    logic [AW-1:0]     mem_addr;
    logic [DATA_W-1:0] mem_wdata;
    logic [DATA_W-1:0] mem_rdata;

    logic              m_valid_reg, m_valid_next;
    out_t              m_data_reg, m_data_next;

    obrb_ctrl #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .p1_take     (p1_take),
        .p1_valid    (p1_valid),
        .p1_data     (p1_data),
        .mem_cmd     (mem_cmd),
        .mem_addr    (mem_addr),
        .mem_wdata   (mem_wdata)
    );

    obrb_store #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .aclk  (aclk),
        .cmd   (mem_cmd),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    assign p1_take = p1_valid && (!m_valid_reg || m_ready);

    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (p1_take) begin
            m_valid_next          = 1'b1;
            m_data_next           = p1_data.res;
            m_data_next.read_byte = p1_data.use_mem ? mem_rdata : '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

### rtl/core/obrb_checker.sv
// Port-level checks for the overwriting byte ring buffer.
// Bound to the top level; uses obrb_pkg for the result word type.
module obrb_checker (
    input logic           aclk,
    input logic           aresetn,
    input logic           m_valid,
    input logic           m_ready,
    input obrb_pkg::out_t m_data
);
    import obrb_pkg::*;

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result word changed while stalled");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    a_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.overwrote |->
            m_data.moved == SIZE_W'(1) && m_data.free_space == '0 && !m_data.byte_valid)
        else $error("overwrite reported on a word that is not a full-buffer write");

    a_byte_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.byte_valid |-> m_data.read_byte == '0)
        else $error("read byte nonzero without a valid byte");

endmodule

bind overwriting_byte_ring_buffer obrb_checker u_obrb_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

### tb/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for overwriting_byte_ring_buffer: random and directed words,
// a built-in predictor of the ring, randomized valid/ready idling and long output holds.
// Depends on obrb_pkg and the overwriting_byte_ring_buffer RTL.
module testbench;
    import obrb_pkg::*;

    localparam int RING_DEPTH       = 1024;
    localparam int HOLD_CYCLES      = 300;
    localparam int CYCLE_LIMIT      = 200000;
    localparam int SHOWN_MISMATCHES = 10;
    localparam int DRAIN_CYCLES     = 10;

    localparam logic [OP_W-1:0] OP_UNUSED_5 = 3'd5;
    localparam logic [OP_W-1:0] OP_UNUSED_6 = 3'd6;
    localparam logic [OP_W-1:0] OP_UNUSED_7 = 3'd7;

    logic              aclk        = 1'b0;
    logic              aresetn     = 1'b0;
    logic              cfg_wr_en   = 1'b0;
    logic [SIZE_W-1:0] cfg_wr_data = '0;
    logic              s_valid     = 1'b0;
    logic              s_ready;
    in_t               s_data      = '0;
    logic              m_valid;
    logic              m_ready     = 1'b0;
    out_t              m_data;

    overwriting_byte_ring_buffer #(
        .DEPTH(RING_DEPTH)
    ) dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    // Predicted ring state
    logic [DATA_W-1:0] ring_mem [RING_DEPTH];
    int unsigned       ring_rd;
    int unsigned       ring_wr;
    int unsigned       ring_fill;
    int unsigned       ring_size;

    in_t         word_q [$];
    out_t        want_q [$];
    out_t        head_res;
    int unsigned words_queued   = 0;
    int unsigned words_taken    = 0;
    int unsigned mismatches     = 0;
    int unsigned cycle_cnt      = 0;
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned hold_left      = 0;
    logic        hold_kick      = 1'b0;

    function automatic void ring_empty();
        ring_rd   = 0;
        ring_wr   = 0;
        ring_fill = 0;
    endfunction

    function automatic int unsigned ring_wrap(int unsigned base, int unsigned step);
        int unsigned s;
        s = base + step;
        if (s >= ring_size) begin
            s = s - ring_size;
        end
        return s;
    endfunction

    function automatic out_t ring_apply(in_t w);
        out_t        r;
        int unsigned n;
        r = '0;
        case (w.op)
            OP_WRITE: begin
                ring_mem[ring_wr % RING_DEPTH] = w.data_byte;
                ring_wr = ring_wrap(ring_wr, 1);
                if (ring_fill >= ring_size) begin
                    r.overwrote = 1'b1;
                    ring_fill   = ring_size;
                    ring_rd     = ring_wr;
                end else begin
                    ring_fill++;
                end
                r.moved = 1;
            end
            OP_POP: begin
                if (ring_fill != 0) begin
                    r.read_byte  = ring_mem[ring_rd % RING_DEPTH];
                    r.byte_valid = 1'b1;
                    r.moved      = 1;
                    ring_rd      = ring_wrap(ring_rd, 1);
                    ring_fill--;
                    if (ring_fill == 0) begin
                        ring_empty();
                    end
                end
            end
            OP_PEEK: begin
                if (w.position < ring_fill) begin
                    r.read_byte  = ring_mem[ring_wrap(ring_rd, w.position) % RING_DEPTH];
                    r.byte_valid = 1'b1;
                end
            end
            OP_ADVANCE: begin
                n = (w.amount < ring_fill) ? w.amount : ring_fill;
                ring_rd   = ring_wrap(ring_rd, n);
                ring_fill = ring_fill - n;
                if (ring_fill == 0) begin
                    ring_empty();
                end
                r.moved = SIZE_W'(n);
            end
            OP_FLUSH: begin
                ring_empty();
            end
            default: begin
            end
        endcase
        r.fill_level = SIZE_W'(ring_fill);
        r.free_space = SIZE_W'(ring_size - ring_fill);
        return r;
    endfunction

    function automatic in_t mk_word(logic [OP_W-1:0] op, int unsigned data, int unsigned amt,
                                    int unsigned pos);
        in_t w;
        w.op        = op;
        w.data_byte = DATA_W'(data);
        w.amount    = SIZE_W'(amt);
        w.position  = POS_W'(pos);
        return w;
    endfunction

    task automatic push_word(in_t w);
        word_q.push_back(w);
        words_queued++;
    endtask

    task automatic wait_idle();
        do begin
            @(negedge aclk);
        end while (!(words_taken == words_queued && want_q.size() == 0));
    endtask

    task automatic set_size(int unsigned v);
        wait_idle();
        repeat (4) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= SIZE_W'(v);
        ring_size = (v == 0) ? 1 : ((v > RING_DEPTH) ? RING_DEPTH : v);
        ring_empty();
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic run_phase(int n, int unsigned sidle, int unsigned rstall, bit hold);
        in_t         w;
        int unsigned r;
        int unsigned span;
        send_idle_pct  = sidle;
        recv_stall_pct = rstall;
        span = (ring_size > RING_DEPTH - 1) ? RING_DEPTH - 1 : ring_size;
        for (int i = 0; i < n; i++) begin
            w.data_byte = DATA_W'($urandom_range(255));
            w.amount    = ($urandom_range(9) < 7) ? SIZE_W'($urandom_range(ring_size))
                                                  : SIZE_W'($urandom_range(2047));
            w.position  = ($urandom_range(9) < 7) ? POS_W'($urandom_range(span))
                                                  : POS_W'($urandom_range(RING_DEPTH - 1));
            r = $urandom_range(99);
            if (r < 45)      w.op = OP_WRITE;
            else if (r < 60) w.op = OP_POP;
            else if (r < 78) w.op = OP_PEEK;
            else if (r < 88) w.op = OP_ADVANCE;
            else if (r < 93) w.op = OP_FLUSH;
            else if (r < 95) w.op = OP_UNUSED_5;
            else if (r < 97) w.op = OP_UNUSED_6;
            else             w.op = OP_UNUSED_7;
            push_word(w);
        end
        if (hold) begin
            @(posedge aclk);
            hold_kick <= 1'b1;
            @(posedge aclk);
            hold_kick <= 1'b0;
        end
        wait_idle();
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                want_q.push_back(ring_apply(s_data));
                words_taken++;
            end
            if (!s_valid || s_ready) begin
                if (word_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    s_valid <= 1'b1;
                    s_data  <= word_q.pop_front();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            hold_left <= 0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (hold_kick) begin
            hold_left <= HOLD_CYCLES;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (want_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= SHOWN_MISMATCHES) begin
                        $display("%0t: unexpected result %p", $realtime, m_data);
                    end
                end else begin
                    head_res = want_q.pop_front();
                    if (m_data.read_byte  !== head_res.read_byte  ||
                        m_data.byte_valid !== head_res.byte_valid ||
                        m_data.moved      !== head_res.moved      ||
                        m_data.overwrote  !== head_res.overwrote  ||
                        m_data.fill_level !== head_res.fill_level ||
                        m_data.free_space !== head_res.free_space) begin
                        mismatches++;
                        if (mismatches <= SHOWN_MISMATCHES) begin
                            $display("%0t: mismatch expected %p actual %p",
                                     $realtime, head_res, m_data);
                        end
                    end
                end
            end
            m_ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        ring_size = RING_DEPTH;
        ring_empty();
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        push_word(mk_word(OP_POP, 0, 0, 0));
        push_word(mk_word(OP_PEEK, 0, 0, 0));
        push_word(mk_word(OP_ADVANCE, 0, RING_DEPTH, 0));
        push_word(mk_word(OP_WRITE, 8'h00, 0, 0));
        push_word(mk_word(OP_WRITE, 8'hFF, 0, 0));
        push_word(mk_word(OP_WRITE, 8'h5A, 0, 0));
        push_word(mk_word(OP_PEEK, 0, 0, 0));
        push_word(mk_word(OP_PEEK, 0, 0, 2));
        push_word(mk_word(OP_PEEK, 0, 0, 3));
        push_word(mk_word(OP_PEEK, 0, 0, RING_DEPTH - 1));
        push_word(mk_word(OP_POP, 0, 0, 0));
        push_word(mk_word(OP_ADVANCE, 0, 0, 0));
        push_word(mk_word(OP_ADVANCE, 0, 2047, 0));
        push_word(mk_word(OP_POP, 0, 0, 0));
        push_word(mk_word(OP_WRITE, 8'h81, 0, 0));
        push_word(mk_word(OP_WRITE, 8'h7E, 0, 0));
        push_word(mk_word(OP_FLUSH, 8'hFF, 2047, RING_DEPTH - 1));
        push_word(mk_word(OP_PEEK, 0, 0, 0));
        push_word(mk_word(OP_UNUSED_5, 8'hFF, 2047, RING_DEPTH - 1));
        push_word(mk_word(OP_UNUSED_6, 8'hFF, 2047, RING_DEPTH - 1));
        push_word(mk_word(OP_UNUSED_7, 8'hFF, 2047, RING_DEPTH - 1));
        push_word(mk_word(OP_WRITE, 8'h33, 0, 0));
        push_word(mk_word(OP_ADVANCE, 0, 1, 0));
        run_phase(60, 0, 0, 1'b1);

        set_size(0);
        run_phase(70, 84, 0, 1'b0);
        set_size(4);
        run_phase(100, 0, 84, 1'b0);
        set_size(2047);
        run_phase(60, 17, 17, 1'b0);
        set_size(5);
        run_phase(90, 17, 17, 1'b0);
        set_size(1);
        run_phase(50, 0, 0, 1'b1);

        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

### overwriting_byte_ring_buffer.f
rtl/core/obrb_pkg.sv
rtl/core/obrb_store.sv
rtl/core/obrb_ctrl.sv
rtl/core/overwriting_byte_ring_buffer.sv
rtl/core/obrb_checker.sv
tb/testbench.sv
